/* hdl/cor_pkg.sv */
// Shared widths, step codes and the control store of the circle outline rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package cor_pkg;

	// Field widths of the item and result words
	localparam int CenterBits  = 15;
	localparam int RadiusBits  = 14;
	localparam int ColorBits   = 32;
	localparam int PixelBits   = 16;
	localparam int StepXBits   = 15;
	localparam int StepYBits   = 16;
	localparam int ErrBits     = 32;
	localparam int CoordBitsDef = 16;

	// Sequencer step numbering
	localparam int StepBits = 4;
	localparam logic [StepBits-1:0] StWait  = 4'd0;
	localparam logic [StepBits-1:0] StSrch  = 4'd1;
	localparam logic [StepBits-1:0] StEmit0 = 4'd2;
	localparam logic [StepBits-1:0] StEmit1 = 4'd3;
	localparam logic [StepBits-1:0] StEmit2 = 4'd4;
	localparam logic [StepBits-1:0] StEmit3 = 4'd5;
	localparam logic [StepBits-1:0] StEmit4 = 4'd6;
	localparam logic [StepBits-1:0] StEmit5 = 4'd7;
	localparam logic [StepBits-1:0] StEmit6 = 4'd8;
	localparam logic [StepBits-1:0] StEmit7 = 4'd9;

	// One control word per step
	typedef struct packed {
		logic                take_in; // wait for an input word
		logic                search;  // walk x along the row
		logic                emit;    // present one pixel word
		logic                go;      // jump to target unconditionally
		logic                swap;    // dx from y, dy from x
		logic                neg_x;   // negate the x offset
		logic                neg_y;   // negate the y offset
		logic                last;    // eighth pixel of the row
		logic [StepBits-1:0] target;  // jump target
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [StepBits-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			StWait:  w.take_in = 1'b1;
			StSrch:  w.search  = 1'b1;
			StEmit0: w.emit    = 1'b1;
			StEmit1: begin w.emit = 1'b1; w.neg_x = 1'b1; end
			StEmit2: begin w.emit = 1'b1; w.neg_y = 1'b1; end
			StEmit3: begin w.emit = 1'b1; w.neg_x = 1'b1; w.neg_y = 1'b1; end
			StEmit4: begin w.emit = 1'b1; w.swap = 1'b1; end
			StEmit5: begin w.emit = 1'b1; w.swap = 1'b1; w.neg_x = 1'b1; end
			StEmit6: begin w.emit = 1'b1; w.swap = 1'b1; w.neg_y = 1'b1; end
			StEmit7: begin
				w.emit   = 1'b1;
				w.swap   = 1'b1;
				w.neg_x  = 1'b1;
				w.neg_y  = 1'b1;
				w.last   = 1'b1;
				w.target = StWait;
			end
			default: begin
				w.go     = 1'b1;
				w.target = StWait;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* hdl/cor_in_if.sv */
// Input channel: one word per row request or circle start.
`timescale 1ns / 1ps
`default_nettype none
interface cor_in_if import cor_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [CenterBits-1:0] center_x;
	logic signed [CenterBits-1:0] center_y;
	logic [RadiusBits-1:0]        radius_in;
	logic [ColorBits-1:0]         color_in;

	modport source (output valid, func, center_x, center_y, radius_in, color_in,
		input ready);
	modport sink (input valid, func, center_x, center_y, radius_in, color_in,
		output ready);
endinterface
`default_nettype wire

/* hdl/cor_out_if.sv */
// Output channel: one pixel write word per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface cor_out_if import cor_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [PixelBits-1:0] pixel_x;
	logic signed [PixelBits-1:0] pixel_y;
	logic [ColorBits-1:0]        pixel_color;
	logic                        row_last;
	logic                        circle_done;

	modport source (output valid, pixel_x, pixel_y, pixel_color, row_last, circle_done,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, row_last, circle_done,
		output ready);
endinterface
`default_nettype wire

/* hdl/circle_outline_rasterizer.sv */
// Circle outline rasterizer: microcoded row walker with eight-way symmetric pixel output.
//
// Usage:
//   req carries one word per row. func = 0 starts a circle (center, radius and
//   colour are latched) and also draws its first row; func = 1 draws the next
//   row of the circle in progress. A func = 1 word with no circle in progress
//   is taken and dropped.
//   pix returns eight pixel words per row, in the order (x,y) (-x,y) (x,-y)
//   (-x,-y) (y,x) (-y,x) (y,-x) (-y,-x) around the centre. row_last marks the
//   eighth word, circle_done marks it on the row at y = 0.
// Sequence:
//   Each row is accepted in the wait step, then walks x in the search step
//   (one step per cycle through the error accumulator) and then presents its
//   eight pixel words. The next word is taken only after the eighth pixel.
//   A circle of radius r costs r + 1 rows.
// Reset and stall:
//   arst_n clears the sequencer to its wait step and drops any circle. When
//   pix.ready is low the current pixel word holds and the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
module circle_outline_rasterizer import cor_pkg::*; #(
	parameter int CoordBits = CoordBitsDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cor_in_if.sink     req,
	cor_out_if.source  pix
);

	logic [StepBits-1:0]          step_q;
	logic [StepBits-1:0]          step_nxt;
	ucode_t                       uc;
	logic [StepXBits-1:0]         step_x_q;
	logic signed [StepYBits-1:0]  step_y_q;
	logic signed [ErrBits-1:0]    err_q;
	logic signed [CenterBits-1:0] held_cx_q;
	logic signed [CenterBits-1:0] held_cy_q;
	logic [RadiusBits-1:0]        held_r_q;
	logic [ColorBits-1:0]         held_color_q;
	logic                         drawing_q;
	logic                         in_fire;
	logic                         out_fire;
	logic                         row_go;
	logic                         walk;
	logic signed [ErrBits-1:0]    inc_x;
	logic signed [ErrBits-1:0]    inc_y;
	logic signed [16:0]           a_mag;
	logic signed [16:0]           b_mag;
	logic signed [16:0]           sum_x;
	logic signed [16:0]           sum_y;

	// Wrap an exact coordinate to CoordBits, then present it in the pixel field
	function automatic logic [PixelBits-1:0] wrap_coord(input logic signed [16:0] v);
		logic signed [31:0]          v32;
		logic signed [CoordBits-1:0] vw;
		logic signed [31:0]          ext;
		v32 = 32'(v);
		vw  = v32[CoordBits-1:0];
		ext = 32'(vw);
		return ext[PixelBits-1:0];
	endfunction

	// Decode the current control word
	assign uc       = ucode_rom(step_q);
	assign req.ready = uc.take_in;
	assign pix.valid = uc.emit;
	assign in_fire  = req.valid && req.ready;
	assign out_fire = pix.valid && pix.ready;
	assign row_go   = in_fire && (!req.func || drawing_q);

	// Keep walking while inside the circle and x has not passed the radius
	assign walk  = uc.search && err_q[ErrBits-1] && (step_x_q <= {1'b0, held_r_q});
	assign inc_x = ErrBits'({step_x_q, 1'b1});
	assign inc_y = ErrBits'($signed({step_y_q, 1'b1}));

	// Step sequencing
	always_comb begin
		step_nxt = step_q;
		priority if (uc.take_in) begin
			if (row_go) step_nxt = step_q + 1'b1;
		end else if (uc.search) begin
			if (!walk) step_nxt = step_q + 1'b1;
		end else if (uc.emit) begin
			if (out_fire) step_nxt = uc.last ? uc.target : step_q + 1'b1;
		end else if (uc.go) begin
			step_nxt = uc.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= StWait;
			drawing_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (in_fire && !req.func) drawing_q <= 1'b1;
			else if (out_fire && uc.last) drawing_q <= (step_y_q != '0);
		end
	end

	// Latch operands, walk x and advance y with the incremental error term
	always_ff @(posedge clk) begin
		if (in_fire && !req.func) begin
			held_cx_q    <= req.center_x;
			held_cy_q    <= req.center_y;
			held_r_q     <= req.radius_in;
			held_color_q <= req.color_in;
			step_x_q     <= '0;
			step_y_q     <= -$signed({2'b00, req.radius_in});
			err_q        <= '0;
		end else if (walk) begin
			step_x_q <= step_x_q + 1'b1;
			err_q    <= err_q + inc_x;
		end else if (out_fire && uc.last) begin
			step_y_q <= step_y_q + StepYBits'(1);
			err_q    <= err_q + inc_y;
		end
	end

	// Form the pixel offset and coordinate for this step
	always_comb begin
		a_mag = uc.swap ? 17'(step_y_q) : $signed({2'b00, step_x_q});
		b_mag = uc.swap ? $signed({2'b00, step_x_q}) : 17'(step_y_q);
		sum_x = 17'(held_cx_q) + (uc.neg_x ? -a_mag : a_mag);
		sum_y = 17'(held_cy_q) + (uc.neg_y ? -b_mag : b_mag);
	end

	assign pix.pixel_x     = wrap_coord(sum_x);
	assign pix.pixel_y     = wrap_coord(sum_y);
	assign pix.pixel_color = held_color_q;
	assign pix.row_last    = uc.last;
	assign pix.circle_done = uc.last && (step_y_q == '0);

	// Pixels only come out of a circle in progress
	a_emit_drawing: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> drawing_q)
		else $error("pixel word without a circle in progress");

	// The block never takes a word while a pixel is on offer
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && pix.valid))
		else $error("input and output active together");

	// After the last pixel of a row the block waits for the next word
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && pix.row_last) |=> req.ready)
		else $error("sequencer did not return to wait after row");

	// The end of the walk leads straight to the first pixel
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.search && !walk) |=> (pix.valid && !pix.row_last))
		else $error("walk did not hand over to pixel output");

	// x never runs past the radius by more than one
	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drawing_q |-> (step_x_q <= StepXBits'(held_r_q) + 1'b1))
		else $error("x walked past the radius");

endmodule
`default_nettype wire
